// ----- rtl/gtsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the generational task-slot pool.
// No dependencies.
package gtsp_pkg;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_QUERY  = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_FLUSH  = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SLOT    = 2'd1;
   localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
   localparam logic [1:0] ST_EMPTY      = 2'd3;

   localparam logic [5:0] MAX_RESULTS = 6'd32;
   localparam logic [5:0] CHILD_MAX   = 6'd63;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        handle;
      logic signed [15:0] priority_req;
      logic               has_parent;
      logic [4:0]         parent_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        result_handle;
      logic [5:0]         child_count;
      logic signed [15:0] task_priority;
      logic               last;
   } rsp_type;

   // One slot's record in the data memory.
   typedef struct packed {
      logic [15:0]        gen;
      logic signed [15:0] prio;
      logic [5:0]         children;
      logic [4:0]         pidx;
      logic [15:0]        pgen;
   } slot_word_type;

   typedef struct packed {
      logic rd_en;
      logic d_we;
      logic l_we;
   } mem_ctl_type;

endpackage

// ----- rtl/gtsp_store.sv -----
`timescale 1ns / 1ps
// Slot data memory and link memory, with a registered read.
// Depends on gtsp_pkg.
module gtsp_store #(
   parameter int SLOTS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gtsp_pkg::mem_ctl_type           ctl,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] d_addr,
   input  gtsp_pkg::slot_word_type         d_wdata,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] l_addr,
   input  logic [$clog2(SLOTS + 1)-1:0]    l_wdata,
   output gtsp_pkg::slot_word_type         d_q,
   output logic [$clog2(SLOTS + 1)-1:0]    l_q
);
   import gtsp_pkg::*;

   localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LinkW = $clog2(SLOTS + 1);
   localparam logic [LinkW-1:0] NIL = LinkW'(SLOTS);

   slot_word_type    d_mem [SLOTS];
   logic [LinkW-1:0] l_mem [SLOTS];

   slot_word_type    d_q_ff;
   logic [LinkW-1:0] l_q_ff;
   logic [IdxW-1:0]  rd_addr_ff;
   logic             gen_ok_ff;
   logic             link_ok_ff;
   logic [SLOTS-1:0] gen_wr_ff;
   logic [SLOTS-1:0] link_wr_ff;

   always_ff @(posedge clock) begin
      if (ctl.d_we) begin
         d_mem[d_addr] <= d_wdata;
      end
      if (ctl.l_we) begin
         l_mem[l_addr] <= l_wdata;
      end
      if (ctl.rd_en) begin
         d_q_ff     <= d_mem[rd_addr];
         l_q_ff     <= l_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // written-once marks: unwritten entries read as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_wr_ff  <= '0;
         link_wr_ff <= '0;
         gen_ok_ff  <= 1'b0;
         link_ok_ff <= 1'b0;
      end else begin
         if (ctl.d_we) begin
            gen_wr_ff[d_addr] <= 1'b1;
         end
         if (ctl.l_we) begin
            link_wr_ff[l_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            gen_ok_ff  <= gen_wr_ff[rd_addr];
            link_ok_ff <= link_wr_ff[rd_addr];
         end
      end
   end

   always_comb begin
      d_q = d_q_ff;
      if (!gen_ok_ff) begin
         d_q = '0;
      end
      if (link_ok_ff) begin
         l_q = l_q_ff;
      end else if (rd_addr_ff == '0) begin
         l_q = NIL;
      end else begin
         l_q = LinkW'(rd_addr_ff) - LinkW'(1);
      end
   end

endmodule

// ----- rtl/generational_task_slot_pool.sv -----
`timescale 1ns / 1ps
// Generational task-slot pool, top level: sequencer, list heads, flags.
// Depends on gtsp_pkg and gtsp_store.
//
// One request is taken at a time; req_ready is high only while the sequencer
// is idle. Every memory access is issued first and its registered read data
// used after, and that one read port sets the pace. Delete and query read
// the handle's slot, then give the result; unknown opcodes and a create with
// no free slot go straight to the result. Create reads the parent slot, then
// the new slot, and writes the parent's child count when it links a parent
// in another slot. Tick frees each marked task on the active list (and lowers
// a live parent's child count), merges the pending tasks by priority, then
// lists the live tasks. Flush frees the pending tasks, then the active ones.
// Results of a tick stream out one per transfer while the walk goes on; a
// result waiting in the output register stalls the walk. Handles carry the
// slot's 16-bit generation in bits 31..16 and the slot in bits 15..0; the
// generation steps by one, wrapping, on each free. No clearing pass after
// reset: the block is ready as soon as reset is released.
module generational_task_slot_pool #(
   parameter int SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gtsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gtsp_pkg::rsp_type rsp_data
);
   import gtsp_pkg::*;

   localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LinkW = $clog2(SLOTS + 1);
   localparam logic [LinkW-1:0] NIL = LinkW'(SLOTS);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_C_RS   = 5'd1;
   localparam logic [4:0] S_C_WS   = 5'd2;
   localparam logic [4:0] S_C_WP   = 5'd3;
   localparam logic [4:0] S_LK_CHK = 5'd4;
   localparam logic [4:0] S_T_NEXT = 5'd5;
   localparam logic [4:0] S_T_CHK  = 5'd6;
   localparam logic [4:0] S_TP_RD  = 5'd7;
   localparam logic [4:0] S_TP_CHK = 5'd8;
   localparam logic [4:0] S_FR_WR  = 5'd9;
   localparam logic [4:0] S_FR_LNK = 5'd10;
   localparam logic [4:0] S_F_NEXT = 5'd11;
   localparam logic [4:0] S_F_CHK  = 5'd12;
   localparam logic [4:0] S_P_NEXT = 5'd13;
   localparam logic [4:0] S_P_CHK  = 5'd14;
   localparam logic [4:0] S_W_NEXT = 5'd15;
   localparam logic [4:0] S_W_CHK  = 5'd16;
   localparam logic [4:0] S_I_WT   = 5'd17;
   localparam logic [4:0] S_I_WP   = 5'd18;
   localparam logic [4:0] S_L_NEXT = 5'd19;
   localparam logic [4:0] S_L_CHK  = 5'd20;
   localparam logic [4:0] S_FIN    = 5'd21;

   // list pointers; any value at or above SLOTS is the null link
   function automatic logic is_slot(input logic [LinkW-1:0] v);
      return 32'(v) < SLOTS;
   endfunction

   logic [4:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [LinkW-1:0]   c_ff, c_in;          // walk cursor / slot being worked on
   logic [LinkW-1:0]   prev_ff, prev_in;
   logic [LinkW-1:0]   t_ff, t_in;          // pending task being merged
   logic [LinkW-1:0]   nxt_ff, nxt_in;
   logic signed [15:0] tprio_ff, tprio_in;
   slot_word_type      wd_ff, wd_in;        // held slot word
   logic [LinkW-1:0]   free_head_ff, free_head_in;
   logic [LinkW-1:0]   free_tail_ff, free_tail_in;
   logic [LinkW-1:0]   pend_head_ff, pend_head_in;
   logic [LinkW-1:0]   act_head_ff, act_head_in;
   logic [SLOTS-1:0]   in_use_ff, in_use_in;
   logic [SLOTS-1:0]   marked_ff, marked_in;
   logic [SLOTS-1:0]   plv_ff, plv_in;      // parent link valid
   logic               tick_mode_ff, tick_mode_in;
   logic               fl_act_ff, fl_act_in;
   logic               have_buf_ff, have_buf_in;
   logic [5:0]         cnt_ff, cnt_in;
   rsp_type            buf_ff, buf_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   mem_ctl_type        ctl;
   logic [IdxW-1:0]    rd_addr, d_addr, l_addr;
   slot_word_type      d_wdata, d_q;
   logic [LinkW-1:0]   l_wdata, l_q;

   logic               emit_req;
   rsp_type            emit_data;
   logic               out_free;
   logic               stall;
   logic               link_en, self_link, lk_ok, par_ok;
   logic [IdxW-1:0]    ci;

   gtsp_store #(.SLOTS(SLOTS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .d_addr  (d_addr),
      .d_wdata (d_wdata),
      .l_addr  (l_addr),
      .l_wdata (l_wdata),
      .d_q     (d_q),
      .l_q     (l_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ci        = IdxW'(c_ff);

   // a result transfer is due but the output register is still full
   assign stall = !out_free &&
                  ((state_ff == S_FIN) ||
                   (state_ff == S_L_CHK && !marked_ff[ci] && have_buf_ff));

   assign link_en   = req_ff.has_parent && (32'(req_ff.parent_slot) < SLOTS);
   assign self_link = link_en && (32'(req_ff.parent_slot) == 32'(c_ff));
   assign lk_ok     = (32'(req_ff.handle[15:0]) < SLOTS) &&
                      in_use_ff[IdxW'(req_ff.handle[15:0])] &&
                      !marked_ff[IdxW'(req_ff.handle[15:0])] &&
                      (d_q.gen == req_ff.handle[31:16]);
   assign par_ok    = (32'(wd_ff.pidx) < SLOTS) &&
                      in_use_ff[IdxW'(wd_ff.pidx)] &&
                      !marked_ff[IdxW'(wd_ff.pidx)] &&
                      (d_q.gen == wd_ff.pgen) && (d_q.children != '0);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      c_in         = c_ff;
      prev_in      = prev_ff;
      t_in         = t_ff;
      nxt_in       = nxt_ff;
      tprio_in     = tprio_ff;
      wd_in        = wd_ff;
      free_head_in = free_head_ff;
      free_tail_in = free_tail_ff;
      pend_head_in = pend_head_ff;
      act_head_in  = act_head_ff;
      in_use_in    = in_use_ff;
      marked_in    = marked_ff;
      plv_in       = plv_ff;
      tick_mode_in = tick_mode_ff;
      fl_act_in    = fl_act_ff;
      have_buf_in  = have_buf_ff;
      cnt_in       = cnt_ff;
      buf_in       = buf_ff;
      ctl          = '0;
      rd_addr      = ci;
      d_addr       = ci;
      d_wdata      = wd_ff;
      l_addr       = ci;
      l_wdata      = NIL;
      emit_req     = 1'b0;
      emit_data    = buf_ff;

      if (!stall) begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_in = req_data;
                  buf_in = '0;
                  case (req_data.opcode)
                     OP_CREATE: begin
                        if (!is_slot(free_head_ff)) begin
                           buf_in.status = ST_NO_SLOT;
                           state_in      = S_FIN;
                        end else begin
                           ctl.rd_en = 1'b1;
                           rd_addr   = IdxW'(req_data.parent_slot);
                           c_in      = free_head_ff;
                           state_in  = S_C_RS;
                        end
                     end
                     OP_DELETE, OP_QUERY: begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = IdxW'(req_data.handle[15:0]);
                        state_in  = S_LK_CHK;
                     end
                     OP_TICK: begin
                        c_in         = act_head_ff;
                        prev_in      = NIL;
                        tick_mode_in = 1'b1;
                        state_in     = S_T_NEXT;
                     end
                     OP_FLUSH: begin
                        c_in         = pend_head_ff;
                        pend_head_in = NIL;
                        fl_act_in    = 1'b0;
                        tick_mode_in = 1'b0;
                        state_in     = S_F_NEXT;
                     end
                     default: begin
                        state_in = S_FIN;
                     end
                  endcase
               end
            end

            // create: parent word in hand, fetch the new slot
            S_C_RS: begin
               wd_in     = d_q;
               ctl.rd_en = 1'b1;
               rd_addr   = ci;
               state_in  = S_C_WS;
            end

            S_C_WS: begin
               free_head_in  = l_q;
               ctl.l_we      = 1'b1;
               l_addr        = ci;
               l_wdata       = pend_head_ff;
               pend_head_in  = c_ff;
               in_use_in[ci] = 1'b1;
               marked_in[ci] = 1'b0;
               plv_in[ci]    = link_en;
               ctl.d_we      = 1'b1;
               d_addr        = ci;
               d_wdata.gen      = d_q.gen;
               d_wdata.prio     = req_ff.priority_req;
               d_wdata.children = self_link ? 6'd1 : 6'd0;
               d_wdata.pidx     = req_ff.parent_slot;
               d_wdata.pgen     = self_link ? d_q.gen : wd_ff.gen;
               buf_in.status        = ST_OK;
               buf_in.result_handle = {d_q.gen, 16'(c_ff)};
               state_in = (link_en && !self_link) ? S_C_WP : S_FIN;
            end

            S_C_WP: begin
               ctl.d_we = 1'b1;
               d_addr   = IdxW'(req_ff.parent_slot);
               d_wdata  = wd_ff;
               if (wd_ff.children != CHILD_MAX) begin
                  d_wdata.children = wd_ff.children + 6'd1;
               end
               state_in = S_FIN;
            end

            S_LK_CHK: begin
               if (!lk_ok) begin
                  buf_in.status = ST_BAD_HANDLE;
               end else if (req_ff.opcode == OP_DELETE) begin
                  marked_in[IdxW'(req_ff.handle[15:0])] = 1'b1;
               end else begin
                  buf_in.result_handle = req_ff.handle;
                  buf_in.child_count   = d_q.children;
                  buf_in.task_priority = d_q.prio;
               end
               state_in = S_FIN;
            end

            // tick, first pass: drop marked tasks from the active list
            S_T_NEXT: begin
               if (is_slot(c_ff)) begin
                  ctl.rd_en = 1'b1;
                  state_in  = S_T_CHK;
               end else begin
                  t_in     = pend_head_ff;
                  state_in = S_P_NEXT;
               end
            end

            S_T_CHK: begin
               nxt_in = l_q;
               if (!marked_ff[ci]) begin
                  prev_in  = c_ff;
                  c_in     = l_q;
                  state_in = S_T_NEXT;
               end else begin
                  wd_in = d_q;
                  if (!is_slot(prev_ff)) begin
                     act_head_in = l_q;
                  end else begin
                     ctl.l_we = 1'b1;
                     l_addr   = IdxW'(prev_ff);
                     l_wdata  = l_q;
                  end
                  state_in = plv_ff[ci] ? S_TP_RD : S_FR_WR;
               end
            end

            S_TP_RD: begin
               ctl.rd_en = 1'b1;
               rd_addr   = IdxW'(wd_ff.pidx);
               state_in  = S_TP_CHK;
            end

            S_TP_CHK: begin
               if (par_ok) begin
                  ctl.d_we         = 1'b1;
                  d_addr           = IdxW'(wd_ff.pidx);
                  d_wdata          = d_q;
                  d_wdata.children = d_q.children - 6'd1;
               end
               state_in = S_FR_WR;
            end

            // free the slot at the cursor
            S_FR_WR: begin
               ctl.d_we      = 1'b1;
               d_wdata       = wd_ff;
               d_wdata.gen   = wd_ff.gen + 16'd1;
               ctl.l_we      = 1'b1;
               l_wdata       = NIL;
               in_use_in[ci] = 1'b0;
               marked_in[ci] = 1'b0;
               state_in      = S_FR_LNK;
            end

            S_FR_LNK: begin
               if (!is_slot(free_head_ff)) begin
                  free_head_in = c_ff;
               end else if (is_slot(free_tail_ff)) begin
                  ctl.l_we = 1'b1;
                  l_addr   = IdxW'(free_tail_ff);
                  l_wdata  = c_ff;
               end
               free_tail_in = c_ff;
               c_in         = nxt_ff;
               state_in     = tick_mode_ff ? S_T_NEXT : S_F_NEXT;
            end

            // flush: pending list, then active list
            S_F_NEXT: begin
               if (is_slot(c_ff)) begin
                  ctl.rd_en = 1'b1;
                  state_in  = S_F_CHK;
               end else if (!fl_act_ff) begin
                  c_in        = act_head_ff;
                  act_head_in = NIL;
                  fl_act_in   = 1'b1;
               end else begin
                  state_in = S_FIN;
               end
            end

            S_F_CHK: begin
               nxt_in   = l_q;
               wd_in    = d_q;
               state_in = S_FR_WR;
            end

            // tick, second pass: merge pending tasks by priority
            S_P_NEXT: begin
               if (is_slot(t_ff)) begin
                  ctl.rd_en = 1'b1;
                  rd_addr   = IdxW'(t_ff);
                  state_in  = S_P_CHK;
               end else begin
                  pend_head_in = NIL;
                  c_in         = act_head_ff;
                  cnt_in       = '0;
                  have_buf_in  = 1'b0;
                  state_in     = S_L_NEXT;
               end
            end

            S_P_CHK: begin
               nxt_in   = l_q;
               tprio_in = d_q.prio;
               c_in     = act_head_ff;
               prev_in  = NIL;
               state_in = S_W_NEXT;
            end

            S_W_NEXT: begin
               if (is_slot(c_ff)) begin
                  ctl.rd_en = 1'b1;
                  state_in  = S_W_CHK;
               end else begin
                  state_in = S_I_WT;
               end
            end

            S_W_CHK: begin
               if ($signed(d_q.prio) < $signed(tprio_ff)) begin
                  state_in = S_I_WT;
               end else begin
                  prev_in  = c_ff;
                  c_in     = l_q;
                  state_in = S_W_NEXT;
               end
            end

            S_I_WT: begin
               ctl.l_we = 1'b1;
               l_addr   = IdxW'(t_ff);
               l_wdata  = c_ff;
               state_in = S_I_WP;
            end

            S_I_WP: begin
               if (!is_slot(prev_ff)) begin
                  act_head_in = t_ff;
               end else begin
                  ctl.l_we = 1'b1;
                  l_addr   = IdxW'(prev_ff);
                  l_wdata  = t_ff;
               end
               t_in     = nxt_ff;
               state_in = S_P_NEXT;
            end

            // tick, third pass: list live tasks; one result held back for last
            S_L_NEXT: begin
               if (is_slot(c_ff) && (cnt_ff < MAX_RESULTS)) begin
                  ctl.rd_en = 1'b1;
                  state_in  = S_L_CHK;
               end else begin
                  if (!have_buf_ff) begin
                     buf_in        = '0;
                     buf_in.status = ST_EMPTY;
                  end
                  state_in = S_FIN;
               end
            end

            S_L_CHK: begin
               if (!marked_ff[ci]) begin
                  if (have_buf_ff) begin
                     emit_req       = 1'b1;
                     emit_data      = buf_ff;
                     emit_data.last = 1'b0;
                  end
                  buf_in.status        = ST_OK;
                  buf_in.result_handle = {d_q.gen, 16'(c_ff)};
                  buf_in.child_count   = d_q.children;
                  buf_in.task_priority = d_q.prio;
                  buf_in.last          = 1'b0;
                  have_buf_in          = 1'b1;
                  cnt_in               = cnt_ff + 6'd1;
               end
               c_in     = l_q;
               state_in = S_L_NEXT;
            end

            S_FIN: begin
               emit_req       = 1'b1;
               emit_data      = buf_ff;
               emit_data.last = 1'b1;
               state_in       = S_IDLE;
            end

            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= LinkW'(SLOTS - 1);
         free_tail_ff <= '0;
         pend_head_ff <= NIL;
         act_head_ff  <= NIL;
         in_use_ff    <= '0;
         marked_ff    <= '0;
         plv_ff       <= '0;
         tick_mode_ff <= 1'b0;
         fl_act_ff    <= 1'b0;
         have_buf_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         free_tail_ff <= free_tail_in;
         pend_head_ff <= pend_head_in;
         act_head_ff  <= act_head_in;
         in_use_ff    <= in_use_in;
         marked_ff    <= marked_in;
         plv_ff       <= plv_in;
         tick_mode_ff <= tick_mode_in;
         fl_act_ff    <= fl_act_in;
         have_buf_ff  <= have_buf_in;
         cnt_ff       <= cnt_in;
         if (emit_req) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      c_ff     <= c_in;
      prev_ff  <= prev_in;
      t_ff     <= t_in;
      nxt_ff   <= nxt_in;
      tprio_ff <= tprio_in;
      wd_ff    <= wd_in;
      buf_ff   <= buf_in;
      if (emit_req) begin
         rsp_ff <= emit_data;
      end
   end

endmodule

// ----- rtl/gtsp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the task-slot pool, bound to the top level.
// Depends on gtsp_pkg and generational_task_slot_pool.
module gtsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input gtsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input gtsp_pkg::rsp_type rsp_data
);
   import gtsp_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_busy_mid_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |-> !req_ready)
      else $error("ready for a request before the last result");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |-> rsp_data.last)
      else $error("empty-list status on a non-final result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

endmodule

bind generational_task_slot_pool gtsp_checker u_gtsp_checker (.*);
